### rtl/aes_pkg.sv
// shared types, tables and round functions for the aes-128 cipher
package aes_pkg;

  localparam int ROUNDS = 10;
  localparam int NUM_KEYS = ROUNDS + 1;
  localparam int STAGES = ROUNDS + 1;

  typedef logic [127:0] aes_blk_t;
  typedef logic [3:0] aes_cnt_t;

  typedef struct packed {
    logic valid;
    logic kind;
  } aes_tag_t;

  localparam logic [7:0] FWD_BOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  localparam logic [7:0] INV_BOX [256] = '{
    8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
    8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
    8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
    8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
    8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
    8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
    8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
    8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
    8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
    8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
    8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
    8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
    8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
    8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
    8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
    8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
  };

  localparam logic [7:0] POLY = 8'h1b;

  function automatic logic [7:0] rcon(input aes_cnt_t k);
    case (k)
      4'd1: rcon = 8'h01;
      4'd2: rcon = 8'h02;
      4'd3: rcon = 8'h04;
      4'd4: rcon = 8'h08;
      4'd5: rcon = 8'h10;
      4'd6: rcon = 8'h20;
      4'd7: rcon = 8'h40;
      4'd8: rcon = 8'h80;
      4'd9: rcon = 8'h1b;
      4'd10: rcon = 8'h36;
      default: rcon = 8'h00;
    endcase
  endfunction

  function automatic logic [7:0] xt(input logic [7:0] a);
    xt = {a[6:0], 1'b0} ^ (a[7] ? POLY : 8'h00);
  endfunction

  function automatic logic [7:0] gbyte(input aes_blk_t s, input int n);
    gbyte = s[127 - 8*n -: 8];
  endfunction

  function automatic aes_blk_t sub_fwd(input aes_blk_t s);
    aes_blk_t t;
    for (int n = 0; n < 16; n++) t[127 - 8*n -: 8] = FWD_BOX[gbyte(s, n)];
    sub_fwd = t;
  endfunction

  function automatic aes_blk_t sub_inv(input aes_blk_t s);
    aes_blk_t t;
    for (int n = 0; n < 16; n++) t[127 - 8*n -: 8] = INV_BOX[gbyte(s, n)];
    sub_inv = t;
  endfunction

  function automatic aes_blk_t shift_fwd(input aes_blk_t s);
    aes_blk_t t;
    for (int c = 0; c < 4; c++)
      for (int r = 0; r < 4; r++)
        t[127 - 8*(4*c + r) -: 8] = gbyte(s, 4*((c + r) % 4) + r);
    shift_fwd = t;
  endfunction

  function automatic aes_blk_t shift_inv(input aes_blk_t s);
    aes_blk_t t;
    for (int c = 0; c < 4; c++)
      for (int r = 0; r < 4; r++)
        t[127 - 8*(4*c + r) -: 8] = gbyte(s, 4*((c + 4 - r) % 4) + r);
    shift_inv = t;
  endfunction

  function automatic aes_blk_t mix_fwd(input aes_blk_t s);
    aes_blk_t t;
    logic [7:0] a0, a1, a2, a3;
    for (int c = 0; c < 4; c++) begin
      a0 = gbyte(s, 4*c);
      a1 = gbyte(s, 4*c + 1);
      a2 = gbyte(s, 4*c + 2);
      a3 = gbyte(s, 4*c + 3);
      t[127 - 8*(4*c) -: 8] = xt(a0) ^ xt(a1) ^ a1 ^ a2 ^ a3;
      t[127 - 8*(4*c + 1) -: 8] = a0 ^ xt(a1) ^ xt(a2) ^ a2 ^ a3;
      t[127 - 8*(4*c + 2) -: 8] = a0 ^ a1 ^ xt(a2) ^ xt(a3) ^ a3;
      t[127 - 8*(4*c + 3) -: 8] = xt(a0) ^ a0 ^ a1 ^ a2 ^ xt(a3);
    end
    mix_fwd = t;
  endfunction

  function automatic logic [7:0] m9(input logic [7:0] a);
    m9 = xt(xt(xt(a))) ^ a;
  endfunction

  function automatic logic [7:0] mb(input logic [7:0] a);
    mb = xt(xt(xt(a))) ^ xt(a) ^ a;
  endfunction

  function automatic logic [7:0] md(input logic [7:0] a);
    md = xt(xt(xt(a))) ^ xt(xt(a)) ^ a;
  endfunction

  function automatic logic [7:0] me(input logic [7:0] a);
    me = xt(xt(xt(a))) ^ xt(xt(a)) ^ xt(a);
  endfunction

  function automatic aes_blk_t mix_inv(input aes_blk_t s);
    aes_blk_t t;
    logic [7:0] a0, a1, a2, a3;
    for (int c = 0; c < 4; c++) begin
      a0 = gbyte(s, 4*c);
      a1 = gbyte(s, 4*c + 1);
      a2 = gbyte(s, 4*c + 2);
      a3 = gbyte(s, 4*c + 3);
      t[127 - 8*(4*c) -: 8] = me(a0) ^ mb(a1) ^ md(a2) ^ m9(a3);
      t[127 - 8*(4*c + 1) -: 8] = m9(a0) ^ me(a1) ^ mb(a2) ^ md(a3);
      t[127 - 8*(4*c + 2) -: 8] = md(a0) ^ m9(a1) ^ me(a2) ^ mb(a3);
      t[127 - 8*(4*c + 3) -: 8] = mb(a0) ^ md(a1) ^ m9(a2) ^ me(a3);
    end
    mix_inv = t;
  endfunction

endpackage

### rtl/aes_key_sched.sv
// round key expansion, one round key per cycle into a register bank
module aes_key_sched import aes_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     restart,
  input  aes_blk_t key,
  output aes_blk_t rk [NUM_KEYS],
  output logic     ready
);

  aes_cnt_t   cnt;
  aes_blk_t   cur;
  aes_blk_t   cur_next;
  logic [31:0] t;

  always_comb begin
    t = {FWD_BOX[cur[23:16]], FWD_BOX[cur[15:8]], FWD_BOX[cur[7:0]], FWD_BOX[cur[31:24]]}
        ^ {rcon(cnt), 24'h0};
    cur_next[127:96] = cur[127:96] ^ t;
    cur_next[95:64] = cur[95:64] ^ cur_next[127:96];
    cur_next[63:32] = cur[63:32] ^ cur_next[95:64];
    cur_next[31:0] = cur[31:0] ^ cur_next[63:32];
  end

  assign ready = (cnt == aes_cnt_t'(NUM_KEYS));

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      cnt <= '0;
    end else if (!ready) begin
      cnt <= cnt + 4'd1;
      if (cnt == '0) begin
        rk[cnt] <= key;
        cur <= key;
      end else begin
        rk[cnt] <= cur_next;
        cur <= cur_next;
      end
    end
  end

endmodule

### rtl/aes_round_cell.sv
// one round of the cipher chain, forward or inverse per word
module aes_round_cell import aes_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     adv,
  input  logic     last,
  input  aes_tag_t tag_in,
  input  aes_blk_t state_in,
  input  aes_blk_t enc_key,
  input  aes_blk_t dec_key,
  output aes_tag_t tag,
  output aes_blk_t state
);

  aes_blk_t state_next;
  aes_blk_t e;
  aes_blk_t d;

  always_comb begin
    e = shift_fwd(sub_fwd(state_in));
    if (!last) e = mix_fwd(e);
    e = e ^ enc_key;
    d = sub_inv(shift_inv(state_in)) ^ dec_key;
    if (!last) d = mix_inv(d);
    state_next = tag_in.kind ? d : e;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tag.valid <= 1'b0;
    end else if (adv) begin
      tag.valid <= tag_in.valid;
    end
    if (adv) begin
      tag.kind <= tag_in.kind;
      state <= state_next;
    end
  end

endmodule

### rtl/aes128_block_cipher.sv
// aes-128 ecb cipher top level: key schedule and a chain of round cells
//
// channel   signals                              direction
// input     in_valid in_stall kind block_*       in
// output    out_valid out_stall out_high out_low out
// config    cfg_we cfg_index cfg_data            in
//
// one word per cycle while out_stall is low and the keys are ready; stages are the entry stage plus ten round cells
// after reset or a key write the schedule runs again, in_stall is high meanwhile
// a stalled output holds its stage; empty stages upstream keep filling
module aes128_block_cipher import aes_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        kind,
  input  logic [63:0] block_high,
  input  logic [63:0] block_low,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] out_high,
  output logic [63:0] out_low,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [63:0] cfg_data
);

  localparam logic KEY_HIGH = 1'b0;
  localparam logic KEY_LOW = 1'b1;

  logic [63:0] key_high;
  logic [63:0] key_low;
  aes_blk_t    rk [NUM_KEYS];
  logic        keys_ready;
  aes_tag_t    tags [STAGES];
  aes_blk_t    states [STAGES];
  logic [STAGES-1:0] en;
  logic        accept;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_high <= '0;
      key_low <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        KEY_HIGH: key_high <= cfg_data;
        KEY_LOW: key_low <= cfg_data;
        default: ;
      endcase
    end
  end

  aes_key_sched u_sched (
    .clk(clk),
    .rst(rst),
    .restart(cfg_we),
    .key({key_high, key_low}),
    .rk(rk),
    .ready(keys_ready)
  );

  always_comb begin
    en[STAGES-1] = !tags[STAGES-1].valid || !out_stall;
    for (int i = STAGES - 2; i >= 0; i--) en[i] = !tags[i].valid || en[i+1];
  end

  assign in_stall = !(en[0] && keys_ready);
  assign accept = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      tags[0].valid <= 1'b0;
    end else if (en[0]) begin
      tags[0].valid <= accept;
    end
    if (en[0]) begin
      tags[0].kind <= kind;
      states[0] <= {block_high, block_low} ^ (kind ? rk[ROUNDS] : rk[0]);
    end
  end

  for (genvar j = 1; j < STAGES; j++) begin : g_cell
    aes_round_cell u_cell (
      .clk(clk),
      .rst(rst),
      .adv(en[j]),
      .last(1'(j == ROUNDS)),
      .tag_in(tags[j-1]),
      .state_in(states[j-1]),
      .enc_key(rk[j]),
      .dec_key(rk[ROUNDS-j]),
      .tag(tags[j]),
      .state(states[j])
    );
  end

  assign out_valid = tags[STAGES-1].valid;
  assign out_high = states[STAGES-1][127:64];
  assign out_low = states[STAGES-1][63:0];

`ifndef SYNTHESIS
  a_no_take_unready: assert property (@(posedge clk) disable iff (rst)
    !keys_ready |-> in_stall) else $error("word taken before key schedule done");
  a_cfg_restarts: assert property (@(posedge clk) disable iff (rst)
    cfg_we |=> !keys_ready) else $error("key write did not restart schedule");
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid) else $error("output valid after reset");
`endif

endmodule

### bench/tb.sv
// self-checking bench for the aes-128 ecb cipher: directed vectors, then random keys and blocks
module tb;
  import aes_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCH_LIMIT = 3000;
  localparam int HOLD_CYCLES = 200;

  typedef enum logic {OP_ENC = 1'b0, OP_DEC = 1'b1} op_e;
  typedef enum logic {REG_KEY_HIGH = 1'b0, REG_KEY_LOW = 1'b1} reg_e;

  typedef struct {
    int          key_set;
    op_e         op;
    logic [63:0] bh;
    logic [63:0] bl;
    bit          known;
    logic [63:0] rh;
    logic [63:0] rl;
  } vector_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        kind = 1'b0;
  logic [63:0] block_high = '0;
  logic [63:0] block_low = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [63:0] out_high;
  logic [63:0] out_low;
  logic        cfg_we = 1'b0;
  logic        cfg_index = 1'b0;
  logic [63:0] cfg_data = '0;

  logic [7:0]   sbox [256];
  logic [7:0]   isbox [256];
  aes_blk_t     round_key [NUM_KEYS];
  logic [63:0]  key_hi = '0;
  logic [63:0]  key_lo = '0;
  aes_blk_t     pending_blocks [$];
  int           errors = 0;
  int           idle_cycles = 0;
  bit           no_gaps = 0;
  bit           hold_req = 0;

  aes128_block_cipher u_top (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic logic [7:0] gf_mul(logic [7:0] a, logic [7:0] b);
    logic [7:0] acc;
    acc = 8'h00;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) acc ^= a;
      a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    end
    return acc;
  endfunction

  function automatic logic [7:0] byte_at(aes_blk_t s, int n);
    return s[127 - 8*n -: 8];
  endfunction

  function automatic aes_blk_t sub_bytes(aes_blk_t s, bit inv);
    aes_blk_t t;
    for (int n = 0; n < 16; n++)
      t[127 - 8*n -: 8] = inv ? isbox[byte_at(s, n)] : sbox[byte_at(s, n)];
    return t;
  endfunction

  function automatic aes_blk_t rotate_rows(aes_blk_t s, int dir);
    aes_blk_t t;
    for (int c = 0; c < 4; c++)
      for (int r = 0; r < 4; r++)
        t[127 - 8*(4*c + r) -: 8] = byte_at(s, 4*((c + dir*r) & 3) + r);
    return t;
  endfunction

  function automatic aes_blk_t mix_columns(aes_blk_t s, logic [7:0] m [4]);
    aes_blk_t t;
    logic [7:0] v;
    for (int c = 0; c < 4; c++)
      for (int r = 0; r < 4; r++) begin
        v = 8'h00;
        for (int k = 0; k < 4; k++) v ^= gf_mul(byte_at(s, 4*c + k), m[(k - r) & 3]);
        t[127 - 8*(4*c + r) -: 8] = v;
      end
    return t;
  endfunction

  function automatic aes_blk_t cipher_block(op_e op, aes_blk_t blk);
    logic [7:0] fm [4] = '{8'h02, 8'h03, 8'h01, 8'h01};
    logic [7:0] im [4] = '{8'h0e, 8'h0b, 8'h0d, 8'h09};
    aes_blk_t s;
    s = blk;
    if (op == OP_ENC) begin
      s ^= round_key[0];
      for (int r = 1; r <= ROUNDS; r++) begin
        s = rotate_rows(sub_bytes(s, 0), 1);
        if (r != ROUNDS) s = mix_columns(s, fm);
        s ^= round_key[r];
      end
    end else begin
      s ^= round_key[ROUNDS];
      for (int r = ROUNDS - 1; r >= 0; r--) begin
        s = sub_bytes(rotate_rows(s, 3), 1) ^ round_key[r];
        if (r != 0) s = mix_columns(s, im);
      end
    end
    return s;
  endfunction

  task automatic build_tables();
    logic [7:0] p, a, x;
    for (int i = 0; i < 256; i++) begin
      a = 8'(i);
      p = (i == 0) ? 8'h00 : 8'h01;
      if (i != 0) for (int e = 0; e < 254; e++) p = gf_mul(p, a);
      x = p ^ {p[6:0], p[7]} ^ {p[5:0], p[7:6]} ^ {p[4:0], p[7:5]} ^ {p[3:0], p[7:4]} ^ 8'h63;
      sbox[i] = x;
      isbox[x] = 8'(i);
    end
  endtask

  task automatic expand_key();
    logic [31:0] w [4*NUM_KEYS];
    logic [31:0] t;
    logic [7:0]  rc;
    rc = 8'h01;
    {w[0], w[1], w[2], w[3]} = {key_hi, key_lo};
    for (int i = 4; i < 4*NUM_KEYS; i++) begin
      t = w[i-1];
      if ((i & 3) == 0) begin
        t = {t[23:0], t[31:24]};
        t = {sbox[t[31:24]], sbox[t[23:16]], sbox[t[15:8]], sbox[t[7:0]]} ^ {rc, 24'h0};
        rc = gf_mul(rc, 8'h02);
      end
      w[i] = w[i-4] ^ t;
    end
    for (int r = 0; r < NUM_KEYS; r++)
      round_key[r] = {w[4*r], w[4*r+1], w[4*r+2], w[4*r+3]};
  endtask

  task automatic drain();
    while (pending_blocks.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  task automatic write_key(bit do_hi, bit do_lo, logic [63:0] hi, logic [63:0] lo);
    drain();
    if (do_hi) begin
      cfg_we <= 1'b1;
      cfg_index <= REG_KEY_HIGH;
      cfg_data <= hi;
      key_hi = hi;
      @(posedge clk);
    end
    if (do_lo) begin
      cfg_we <= 1'b1;
      cfg_index <= REG_KEY_LOW;
      cfg_data <= lo;
      key_lo = lo;
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    expand_key();
  endtask

  task automatic send_word(op_e op, logic [63:0] bh, logic [63:0] bl);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    kind <= op;
    block_high <= bh;
    block_low <= bl;
    forever begin
      @(negedge clk);
      if (!in_stall) break;
    end
    @(posedge clk);
    pending_blocks.push_back(cipher_block(op, {bh, bl}));
  endtask

  // receiver: random stalls, one long hold on request
  initial begin
    int n;
    aes_blk_t want;
    logic [63:0] gh, gl;
    @(negedge rst);
    forever begin
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 0;
      end
      n = no_gaps ? 0 : $urandom_range(0, 11);
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
      forever begin
        @(negedge clk);
        if (out_valid) break;
      end
      gh = out_high;
      gl = out_low;
      @(posedge clk);
      if (pending_blocks.size() == 0) begin
        $display("%0t unexpected word %h %h", $time, gh, gl);
        errors++;
      end else begin
        want = pending_blocks.pop_front();
        if (gh !== want[127:64]) begin
          $display("%0t out_high expected %h actual %h", $time, want[127:64], gh);
          errors++;
        end
        if (gl !== want[63:0]) begin
          $display("%0t out_low expected %h actual %h", $time, want[63:0], gl);
          errors++;
        end
      end
    end
  end

  always @(negedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || rst || cfg_we)
      idle_cycles <= 0;
    else if (idle_cycles >= WATCH_LIMIT) begin
      $display("** aes128_block_cipher: FAILED **");
      $finish;
    end else
      idle_cycles <= idle_cycles + 1;
  end

  initial begin
    vector_t vec [] = '{
      '{0, OP_ENC, 64'h0, 64'h0, 1, 64'h66e94bd4ef8a2c3b, 64'h884cfa59ca342b2e},
      '{0, OP_DEC, 64'h66e94bd4ef8a2c3b, 64'h884cfa59ca342b2e, 1, 64'h0, 64'h0},
      '{0, OP_ENC, '1, '1, 0, 0, 0},
      '{0, OP_DEC, '1, '1, 0, 0, 0},
      '{0, OP_DEC, 64'h0, 64'h0, 0, 0, 0},
      '{1, OP_ENC, 64'h0011223344556677, 64'h8899aabbccddeeff, 1,
        64'h69c4e0d86a7b0430, 64'hd8cdb78070b4c55a},
      '{1, OP_DEC, 64'h69c4e0d86a7b0430, 64'hd8cdb78070b4c55a, 1,
        64'h0011223344556677, 64'h8899aabbccddeeff},
      '{1, OP_ENC, 64'h8000000000000000, 64'h0, 0, 0, 0},
      '{1, OP_DEC, 64'h0, 64'h1, 0, 0, 0},
      '{2, OP_ENC, '1, 64'h0, 0, 0, 0},
      '{2, OP_DEC, 64'h0, '1, 0, 0, 0},
      '{2, OP_ENC, 64'h0123456789abcdef, 64'hfedcba9876543210, 0, 0, 0}
    };
    int cur_set;
    op_e op;
    logic [63:0] rh, rl;
    build_tables();
    expand_key();
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    cur_set = 0;
    foreach (vec[i]) begin
      if (vec[i].key_set != cur_set) begin
        cur_set = vec[i].key_set;
        in_valid <= 1'b0;
        if (cur_set == 1) write_key(1, 1, 64'h0001020304050607, 64'h08090a0b0c0d0e0f);
        else write_key(1, 1, '1, '1);
      end
      send_word(vec[i].op, vec[i].bh, vec[i].bl);
      if (vec[i].known && pending_blocks[$] !== {vec[i].rh, vec[i].rl}) begin
        $display("%0t vector %0d expected %h%h actual %h", $time, i, vec[i].rh, vec[i].rl,
                 pending_blocks[$]);
        errors++;
      end
    end
    in_valid <= 1'b0;

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: write_key(1, 1, {$urandom, $urandom}, {$urandom, $urandom});
        1: write_key(1, 0, 64'h0, key_lo);
        2: write_key(0, 1, key_hi, {$urandom, $urandom});
        3: write_key(1, 1, 64'h0, 64'h0);
        default: write_key(1, 1, {$urandom, $urandom}, {$urandom, $urandom});
      endcase
      no_gaps = (ph == 4);
      if (ph == 2) hold_req = 1;
      for (int k = 0; k < 240; k++) begin
        op = op_e'($urandom_range(0, 1));
        rh = {$urandom, $urandom};
        rl = {$urandom, $urandom};
        send_word(op, rh, rl);
      end
      in_valid <= 1'b0;
      no_gaps = 0;
    end

    drain();
    if (errors == 0)
      $display("** aes128_block_cipher: PASSED **");
    else
      $display("** aes128_block_cipher: FAILED **");
    $finish;
  end
endmodule

### aes128_block_cipher.f
rtl/aes_pkg.sv
rtl/aes_key_sched.sv
rtl/aes_round_cell.sv
rtl/aes128_block_cipher.sv
bench/tb.sv
